@@ rtl/core/trb_pkg.sv @@
// Shared types and constants for the record bundler.
package trb_pkg;

  localparam int BUFFER_BYTES_DEF = 8192;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int POS_W = 15;
  localparam logic [7:0] ADDRESS_ID = 8'h16;

  typedef enum logic {
    OP_STREAM = 1'b0,
    OP_DRAIN  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_BYTE    = 2'd0,
    ST_IDLE    = 2'd1,
    ST_REFUSED = 2'd2,
    ST_STOPPED = 2'd3
  } status_t;

  typedef enum logic {
    REG_ADDR_OFFSET = 1'b0,
    REG_PACKET_MODE = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_packet;
    status_t    status;
  } result_t;

  typedef struct packed {
    status_t    status;
    logic       last;
    logic       use_ram;
    logic [7:0] imm;
  } desc_t;

endpackage

@@ rtl/core/trb_ram.sv @@
// Generic simple dual-port RAM with registered read.
module trb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/trb_queue.sv @@
// Short result queue between the request front end and the output.
module trb_queue import trb_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  localparam int PW = $clog2(DEPTH),
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  result_t         push_data,
  input  logic            pop,
  output result_t         head,
  output logic            not_empty,
  output logic [CNTW-1:0] count
);

  result_t         slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic            do_pop;

  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNTW'(push) - CNTW'(do_pop);
    end
  end

endmodule

@@ rtl/core/trb_front.sv @@
// Request front end: record parser, packet store addressing and send control.
module trb_front import trb_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int AW = $clog2(BUFFER_BYTES),
  localparam int FW = $clog2(BUFFER_BYTES + 2),
  localparam int CW = ((FW > POS_W) ? FW : POS_W) + 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  item_t         item,
  input  logic [31:0]   addr_offset,
  input  logic          packet_mode,
  output logic          we,
  output logic [AW-1:0] waddr,
  output logic [7:0]    wdata,
  output logic          re,
  output logic [AW-1:0] raddr,
  output logic          desc_valid,
  output desc_t         desc
);

  typedef enum logic [1:0] {
    PH_ID,
    PH_LEN,
    PH_VALUE
  } phase_t;

  phase_t           phase, phase_next;
  logic [FW-1:0]    fill_count, fill_count_next;
  logic [7:0]       record_id, record_id_next;
  logic [8:0]       bytes_left, bytes_left_next;
  logic [FW-1:0]    field_start, field_start_next;
  logic [31:0]      address_sum, address_sum_next;
  logic [31:0]      sum, sum_next;
  logic [POS_W-1:0] send_position, send_position_next;
  logic             sending, sending_next;
  logic             stopped, stopped_next;

  logic [CW-1:0]    fill_x, pos_x, idx, total, tail_gap, need;
  logic             last;
  logic             emit;
  desc_t            d;
  logic [31:0]      shifted_sum;

  always_comb begin
    fill_x = CW'(fill_count);
    pos_x  = CW'(send_position);
    total  = fill_x + (packet_mode ? CW'(2) : CW'(0));
    idx    = packet_mode ? pos_x - CW'(2) : pos_x;
    tail_gap = fill_x - CW'(1) - idx;
    last   = (pos_x + CW'(1)) >= total;
    need   = fill_x + CW'(2) + CW'(item.data_byte);
    shifted_sum = {address_sum[23:0], item.data_byte};

    phase_next         = phase;
    fill_count_next    = fill_count;
    record_id_next     = record_id;
    bytes_left_next    = bytes_left;
    field_start_next   = field_start;
    address_sum_next   = address_sum;
    sum_next           = sum;
    send_position_next = send_position;
    sending_next       = sending;
    stopped_next       = stopped;

    we    = 1'b0;
    waddr = fill_count[AW-1:0];
    wdata = item.data_byte;
    re    = 1'b0;
    raddr = idx[AW-1:0];
    emit  = 1'b0;
    d     = '{status: ST_BYTE, last: 1'b0, use_ram: 1'b0, imm: 8'd0};

    if (take) begin
      if (stopped) begin
        emit     = 1'b1;
        d.status = ST_STOPPED;
      end else if (item.operation == OP_DRAIN) begin
        emit = 1'b1;
        if (!sending) begin
          d.status = ST_IDLE;
        end else begin
          d.last = last;
          if (packet_mode && send_position == '0) begin
            d.imm = fill_x[7:0];
          end else if (packet_mode && send_position == POS_W'(1)) begin
            d.imm = fill_x[15:8];
          end else if (idx < fill_x) begin
            if (idx >= CW'(field_start)) begin
              d.imm = (tail_gap < CW'(4)) ? 8'(sum >> (8 * tail_gap[1:0])) : 8'd0;
            end else begin
              d.use_ram = 1'b1;
              re        = 1'b1;
            end
          end
          if (last) begin
            sending_next       = 1'b0;
            fill_count_next    = '0;
            send_position_next = '0;
          end else begin
            send_position_next = send_position + 1'b1;
          end
        end
      end else if (sending) begin
        emit     = 1'b1;
        d.status = ST_REFUSED;
      end else begin
        unique case (phase)
          PH_ID: begin
            we              = fill_x < CW'(BUFFER_BYTES);
            fill_count_next = fill_count + 1'b1;
            record_id_next  = item.data_byte;
            phase_next      = PH_LEN;
          end
          PH_LEN: begin
            if (need > CW'(BUFFER_BYTES)) begin
              stopped_next = 1'b1;
              emit         = 1'b1;
              d.status     = ST_STOPPED;
            end else begin
              we               = 1'b1;
              fill_count_next  = fill_count + 1'b1;
              field_start_next = fill_count + 1'b1;
              bytes_left_next  = {1'b0, item.data_byte} + 9'd1;
              address_sum_next = '0;
              phase_next       = PH_VALUE;
            end
          end
          default: begin
            we               = fill_x < CW'(BUFFER_BYTES);
            fill_count_next  = fill_count + 1'b1;
            address_sum_next = shifted_sum;
            bytes_left_next  = bytes_left - 9'd1;
            if (bytes_left == 9'd1) begin
              phase_next = PH_ID;
              if (record_id == ADDRESS_ID) begin
                sum_next           = shifted_sum + addr_offset;
                sending_next       = 1'b1;
                send_position_next = '0;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_ID;
      fill_count    <= '0;
      record_id     <= '0;
      bytes_left    <= '0;
      field_start   <= '0;
      address_sum   <= '0;
      sum           <= '0;
      send_position <= '0;
      sending       <= 1'b0;
      stopped       <= 1'b0;
      desc_valid    <= 1'b0;
    end else begin
      phase         <= phase_next;
      fill_count    <= fill_count_next;
      record_id     <= record_id_next;
      bytes_left    <= bytes_left_next;
      field_start   <= field_start_next;
      address_sum   <= address_sum_next;
      sum           <= sum_next;
      send_position <= send_position_next;
      sending       <= sending_next;
      stopped       <= stopped_next;
      desc_valid    <= emit;
    end
    desc <= d;
  end

endmodule

@@ rtl/core/tlv_record_bundler_rebase.sv @@
// Top level of the record bundler with address rebasing.
// A request's result, if any, is registered in the front end, then queued, then offered.
// Throughput is one request per cycle while item_stall is low, held by a four-entry
// result queue and a packet store with one write port and one registered read port.
// Synchronous reset clears the parser, send state, queue and registers; the
// packet store is not cleared and needs no clearing pass.
module tlv_record_bundler_rebase import trb_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  logic [31:0]     addr_offset;
  logic            packet_mode;
  reg_index_t      reg_sel;
  logic            take;
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [7:0]      wdata, rdata;
  logic            desc_valid;
  desc_t           desc;
  result_t         resolved;
  logic [CNTW-1:0] count;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[2]);

  always_comb begin
    unique case (reg_sel)
      REG_ADDR_OFFSET: prdata = addr_offset;
      default:         prdata = {31'd0, packet_mode};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_offset <= '0;
      packet_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_ADDR_OFFSET: addr_offset <= pwdata;
        default:         packet_mode <= pwdata[0];
      endcase
    end
  end

  assign item_stall = ((CNTW + 1)'(count) + (CNTW + 1)'(desc_valid)) >=
                      (CNTW + 1)'(QUEUE_DEPTH);
  assign take = item_valid && !item_stall;

  trb_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .item         (item),
    .addr_offset  (addr_offset),
    .packet_mode  (packet_mode),
    .we           (we),
    .waddr        (waddr),
    .wdata        (wdata),
    .re           (re),
    .raddr        (raddr),
    .desc_valid   (desc_valid),
    .desc         (desc)
  );

  trb_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    resolved.out_byte       = desc.use_ram ? rdata : desc.imm;
    resolved.last_of_packet = desc.last;
    resolved.status         = desc.status;
  end

  trb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (desc_valid),
    .push_data (resolved),
    .pop       (!result_stall),
    .head      (result),
    .not_empty (result_valid),
    .count     (count)
  );

endmodule

@@ sim/tlv_record_bundler_rebase_tb.sv @@
// Self-checking testbench for the record bundler: random records, drains and register settings.
`timescale 1ns / 1ps

module tlv_record_bundler_rebase_tb;
  import trb_pkg::*;

  localparam int BUF = BUFFER_BYTES_DEF;
  localparam int LIMIT = 1000000;

  typedef enum logic [1:0] {
    PP_ID    = 2'd0,
    PP_LEN   = 2'd1,
    PP_VALUE = 2'd2
  } parse_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       req_item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tlv_record_bundler_rebase u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (req_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Register copies and packet state as the block should hold them.
  logic [31:0] base_q = '0;
  logic        mode_q = 1'b0;
  logic [7:0]  store [0:BUF-1];
  logic [13:0] fill = '0;
  parse_t      phase = PP_ID;
  logic [7:0]  rec_id = '0;
  logic [8:0]  left = '0;
  logic [13:0] fstart = '0;
  logic [8:0]  flen = '0;
  logic [31:0] asum = '0;
  logic [14:0] send_pos = '0;
  logic        sending = 1'b0;
  logic        halted = 1'b0;

  item_t       stream_q [$];
  result_t     owed_results [$];
  int unsigned pushed = 0;
  int unsigned errors = 0;
  int unsigned results_taken = 0;
  int unsigned cycles = 0;
  logic        in_busy = 1'b0;
  logic        quiet = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        held_once = 1'b0;

  function automatic void owe(input logic [7:0] ob, input logic last, input status_t st);
    owed_results.push_back(result_t'{out_byte: ob, last_of_packet: last, status: st});
  endfunction

  task automatic bundle_request(input item_t req);
    logic [7:0]  b;
    logic [7:0]  ob;
    logic [31:0] sum;
    logic        last;
    int unsigned p;
    int unsigned total;
    int unsigned idx;
    int          k;
    b = req.data_byte;
    if (halted) begin
      owe(8'h00, 1'b0, ST_STOPPED);
    end else if (req.operation == OP_DRAIN) begin
      if (!sending) begin
        owe(8'h00, 1'b0, ST_IDLE);
      end else begin
        p = send_pos;
        total = fill + (mode_q ? 2 : 0);
        if (mode_q && p == 0) begin
          ob = fill[7:0];
        end else if (mode_q && p == 1) begin
          ob = {2'b00, fill[13:8]};
        end else begin
          idx = mode_q ? p - 2 : p;
          ob = (idx < BUF && idx < fill) ? store[idx] : 8'h00;
        end
        last = (p + 1 >= total);
        if (last) begin
          sending = 1'b0;
          fill = '0;
          send_pos = '0;
        end else begin
          send_pos = 15'(p + 1);
        end
        owe(ob, last, ST_BYTE);
      end
    end else if (sending) begin
      owe(8'h00, 1'b0, ST_REFUSED);
    end else begin
      case (phase)
        PP_ID: begin
          if (fill < BUF) store[fill] = b;
          fill = fill + 1;
          rec_id = b;
          phase = PP_LEN;
        end
        PP_LEN: begin
          if (32'(fill) + 32'(b) + 32'd2 > BUF) begin
            halted = 1'b1;
            owe(8'h00, 1'b0, ST_STOPPED);
          end else begin
            store[fill] = b;
            fill = fill + 1;
            fstart = fill;
            flen = 9'(b) + 9'd1;
            left = 9'(b) + 9'd1;
            asum = '0;
            phase = PP_VALUE;
          end
        end
        default: begin
          if (fill < BUF) store[fill] = b;
          fill = fill + 1;
          asum = {asum[23:0], b};
          if (left != 0) left = left - 1;
          if (left == 0) begin
            phase = PP_ID;
            if (rec_id == ADDRESS_ID) begin
              sum = asum + base_q;
              for (k = int'(flen) - 1; k >= 0; k--) begin
                if (int'(fstart) + k < BUF) store[int'(fstart) + k] = sum[7:0];
                sum = sum >> 8;
              end
              sending = 1'b1;
              send_pos = '0;
            end
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) begin
      bundle_request(req_item);
      in_busy = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!in_busy) begin
      if (gap_left != 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (!quiet && stream_q.size() != 0 && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(0, 4);
        item_valid <= 1'b0;
      end else if (stream_q.size() != 0) begin
        req_item <= stream_q.pop_front();
        item_valid <= 1'b1;
        in_busy = 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // The receiver once refuses results for a long stretch so that the block backs up.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (!held_once && results_taken >= 100) begin
      held_once = 1'b1;
      hold_left = 59;
      result_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_taken++;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("cycle %0d: unexpected result byte %02h last %0d status %0d",
                   cycles, result.out_byte, result.last_of_packet, result.status);
      end else begin
        want = owed_results.pop_front();
        if (result.out_byte !== want.out_byte ||
            result.last_of_packet !== want.last_of_packet ||
            result.status !== want.status) begin
          errors++;
          if (errors <= 10)
            $display("cycle %0d: expected %02h/%0d/%0d got %02h/%0d/%0d (byte/last/status)",
                     cycles, want.out_byte, want.last_of_packet, want.status,
                     result.out_byte, result.last_of_packet, result.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_req(input op_t op, input logic [7:0] b);
    stream_q.push_back(item_t'{operation: op, data_byte: b});
    pushed++;
  endtask

  task automatic wait_idle();
    while (stream_q.size() != 0 || in_busy || owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input reg_index_t idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_ADDR_OFFSET) base_q = val;
    else mode_q = val[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Well-formed packets with random records, each drained in full, with stray requests mixed in.
  task automatic gen_records(input int unsigned n_items);
    int unsigned start;
    int unsigned gfill;
    int unsigned len;
    int unsigned total;
    int unsigned r;
    logic [7:0]  id;
    start = pushed;
    gfill = 0;
    while (pushed - start < n_items || gfill != 0) begin
      if (gfill == 0 && $urandom_range(0, 11) == 0) begin
        push_req(OP_DRAIN, 8'($urandom));
      end else begin
        id = 8'($urandom);
        if ($urandom_range(0, 2) == 0 || pushed - start >= n_items) id = ADDRESS_ID;
        r = $urandom_range(0, 99);
        len = r < 85 ? $urandom_range(0, 7) : r < 97 ? $urandom_range(8, 63)
                                                     : $urandom_range(64, 255);
        if (gfill + len + 3 > 2000) begin
          id = ADDRESS_ID;
          len = $urandom_range(0, 7);
        end
        push_req(OP_STREAM, id);
        push_req(OP_STREAM, len[7:0]);
        repeat (len + 1) push_req(OP_STREAM, 8'($urandom));
        gfill += len + 3;
        if (id == ADDRESS_ID) begin
          total = gfill + (mode_q ? 2 : 0);
          repeat (total) begin
            if ($urandom_range(0, 9) == 0) push_req(OP_STREAM, 8'($urandom));
            push_req(OP_DRAIN, 8'($urandom));
          end
          gfill = 0;
        end
      end
    end
  endtask

  initial begin
    int ph;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A packet whose address field is longer than four bytes and wraps on rebasing,
    // drained with a length prefix and finished without one, past its end.
    apb_write(REG_ADDR_OFFSET, 32'h0000_0100);
    apb_write(REG_PACKET_MODE, 32'd1);
    push_req(OP_DRAIN, 8'h00);
    push_req(OP_STREAM, ADDRESS_ID);
    push_req(OP_STREAM, 8'h04);
    push_req(OP_STREAM, 8'h80);
    repeat (4) push_req(OP_STREAM, 8'hFF);
    push_req(OP_STREAM, 8'h5A);
    repeat (8) push_req(OP_DRAIN, 8'hFF);
    wait_idle();
    apb_write(REG_PACKET_MODE, 32'd0);
    push_req(OP_DRAIN, 8'h00);
    push_req(OP_DRAIN, 8'h00);

    // A plain record, then a one-byte address record; the prefix is switched on mid-packet.
    push_req(OP_STREAM, 8'hFF);
    push_req(OP_STREAM, 8'h00);
    push_req(OP_STREAM, 8'h00);
    push_req(OP_STREAM, ADDRESS_ID);
    push_req(OP_STREAM, 8'h00);
    push_req(OP_STREAM, 8'h01);
    repeat (2) push_req(OP_DRAIN, 8'h00);
    wait_idle();
    apb_write(REG_PACKET_MODE, 32'd1);
    repeat (6) push_req(OP_DRAIN, 8'hFF);

    for (ph = 0; ph < 6; ph++) begin
      wait_idle();
      apb_write(REG_ADDR_OFFSET, ph == 0 ? 32'h0 : ph == 1 ? 32'hFFFF_FFFF : $urandom);
      apb_write(REG_PACKET_MODE, ph % 2);
      gen_records(150);
    end

    // A last stretch of packets with no idling on either side.
    wait_idle();
    quiet = 1'b1;
    apb_write(REG_ADDR_OFFSET, $urandom);
    apb_write(REG_PACKET_MODE, 32'd1);
    gen_records(60);

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ tlv_record_bundler_rebase.f @@
rtl/core/trb_pkg.sv
rtl/core/trb_ram.sv
rtl/core/trb_queue.sv
rtl/core/trb_front.sv
rtl/core/tlv_record_bundler_rebase.sv
sim/tlv_record_bundler_rebase_tb.sv
